@@ hw/rtl/c2dzb_pkg.sv @@
// Shared constants and codes for the 3x3-style streaming 2D convolution core
package c2dzb_pkg;

    // Default sizes handed to the top level
    localparam int KERNEL_SIZE_DEF = 3;
    localparam int MAX_WIDTH_DEF   = 1024;

    // Fixed field widths
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 38;
    localparam int ROW_W      = 12;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int MAX_HEIGHT = 4096;

    // Item operation codes
    localparam logic OP_LOAD_COEF = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_WID_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_HGT_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;

endpackage

@@ hw/rtl/conv2d_same_size_zero_border_core.sv @@
// Streaming KxK convolution with line store, sliding window and zero border
// Path: an emitting pixel word moves through the input, window, product and row-sum
//   stages and the output register to out_valid. Throughput: one word per cycle unless
//   out_ready stalls, set by one line store read and one write per cycle.
// Reset: kernel, window, counters and all stage valids clear; line store is
//   not cleared and only reaches border outputs, which are forced to zero.
module conv2d_same_size_zero_border_core #(
    parameter int KERNEL_SIZE = c2dzb_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = c2dzb_pkg::MAX_WIDTH_DEF,
    localparam int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [c2dzb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [c2dzb_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [c2dzb_pkg::COEF_IDX_W-1:0]    coef_row,
    input  logic [c2dzb_pkg::COEF_IDX_W-1:0]    coef_col,
    input  logic signed [c2dzb_pkg::DATA_W-1:0] coef_value,
    input  logic signed [c2dzb_pkg::DATA_W-1:0] pixel,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [c2dzb_pkg::ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]                    out_col,
    output logic signed [c2dzb_pkg::SUM_W-1:0]  out_value,
    output logic                                is_border
);

    localparam int DATA_W  = c2dzb_pkg::DATA_W;
    localparam int PROD_W  = c2dzb_pkg::PROD_W;
    localparam int SUM_W   = c2dzb_pkg::SUM_W;
    localparam int ROW_W   = c2dzb_pkg::ROW_W;
    localparam int HGT_W   = c2dzb_pkg::CFG_HGT_W;
    localparam int OFFSET  = KERNEL_SIZE / 2;
    localparam int WID_W   = COL_W + 1;
    localparam int EXT_W   = (WID_W > c2dzb_pkg::CFG_WID_W) ? WID_W : c2dzb_pkg::CFG_WID_W;
    localparam int POS_W   = ROW_W + COL_W;
    localparam int LS_ROWS = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
    localparam int LS_W    = LS_ROWS * DATA_W;
    localparam int RSUM_W  = PROD_W + 3;

    // ------------------------------------------------------------------
    // Configuration registers and effective frame size
    // ------------------------------------------------------------------
    logic [c2dzb_pkg::CFG_WID_W-1:0] width_reg;
    logic [HGT_W-1:0]                height_reg;
    logic                            cfg_hit;
    logic [EXT_W-1:0]                width_ext;
    logic [WID_W-1:0]                w_eff;
    logic [HGT_W-1:0]                h_eff;

    assign cfg_hit = cfg_wr_en &&
                     (cfg_addr == c2dzb_pkg::REG_IMAGE_WIDTH ||
                      cfg_addr == c2dzb_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c2dzb_pkg::IMAGE_WIDTH_RST;
            height_reg <= c2dzb_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                c2dzb_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_wdata[c2dzb_pkg::CFG_WID_W-1:0];
                c2dzb_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_wdata[HGT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to 1..MAX_HEIGHT
    assign width_ext = EXT_W'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WID_W'(1);
        else if (width_ext > EXT_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(width_ext);

        if (height_reg == '0)
            h_eff = HGT_W'(1);
        else if (height_reg > HGT_W'(c2dzb_pkg::MAX_HEIGHT))
            h_eff = HGT_W'(c2dzb_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic in_fire, mv1, mv2, mv3, mv4;

    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy4     = !s4_valid_reg || rdy_out;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && rdy1;
    assign mv1      = s1_valid_reg && rdy2;
    assign mv2      = s2_valid_reg && rdy3;
    assign mv3      = s3_valid_reg && rdy4;
    assign mv4      = s4_valid_reg && rdy_out;

    // ------------------------------------------------------------------
    // Raster counters: input column/row, raster index, output position
    // ------------------------------------------------------------------
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [POS_W-1:0] pos_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [POS_W-1:0] lag;
    logic             emit;
    logic             col_last, row_last, ocol_last, frame_end;
    logic             pix_fire;
    logic             border;

    assign pix_fire  = in_fire && (op == c2dzb_pkg::OP_PIXEL);
    assign lag       = POS_W'(OFFSET) * (POS_W'(w_eff) + POS_W'(1));
    assign emit      = pos_reg >= lag;
    assign col_last  = (WID_W'(in_col_reg) + WID_W'(1)) == w_eff;
    assign row_last  = ((HGT_W)'(in_row_reg) + HGT_W'(1)) == h_eff;
    assign frame_end = col_last && row_last;
    assign ocol_last = (WID_W'(ocol_reg) + WID_W'(1)) == w_eff;

    // Border band around the output frame
    assign border = (orow_reg < ROW_W'(OFFSET)) ||
                    ((HGT_W+1)'(orow_reg) + (HGT_W+1)'(OFFSET) >= (HGT_W+1)'(h_eff)) ||
                    (ocol_reg < COL_W'(OFFSET)) ||
                    ((WID_W+1)'(ocol_reg) + (WID_W+1)'(OFFSET) >= (WID_W+1)'(w_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            pos_reg    <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            // restart the frame on any register write
            in_col_reg <= '0;
            in_row_reg <= '0;
            pos_reg    <= '0;
            orow_reg   <= '0;
            ocol_reg   <= '0;
        end
        else if (pix_fire)
        begin
            if (frame_end)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                pos_reg    <= '0;
                orow_reg   <= '0;
                ocol_reg   <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (col_last)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
                if (emit)
                begin
                    if (ocol_last)
                    begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        ocol_reg <= ocol_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the accepted word and its output position
    // ------------------------------------------------------------------
    logic                           s1_op_reg;
    logic [c2dzb_pkg::COEF_IDX_W-1:0] s1_coef_row_reg;
    logic [c2dzb_pkg::COEF_IDX_W-1:0] s1_coef_col_reg;
    logic signed [DATA_W-1:0]       s1_coef_reg;
    logic signed [DATA_W-1:0]       s1_pixel_reg;
    logic [COL_W-1:0]               s1_col_reg;
    logic                           s1_emit_reg;
    logic [ROW_W-1:0]               s1_orow_reg;
    logic [COL_W-1:0]               s1_ocol_reg;
    logic                           s1_border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (mv1)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg       <= op;
            s1_coef_row_reg <= coef_row;
            s1_coef_col_reg <= coef_col;
            s1_coef_reg     <= coef_value;
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= in_col_reg;
            s1_emit_reg     <= emit;
            s1_orow_reg     <= orow_reg;
            s1_ocol_reg     <= ocol_reg;
            s1_border_reg   <= border;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column holds the last rows of that column
    // ------------------------------------------------------------------
    logic [LS_W-1:0]          line_mem [MAX_WIDTH];
    logic [LS_W-1:0]          line_rd_reg;
    logic [LS_W-1:0]          ls_wdata;
    logic                     ls_we;
    logic signed [DATA_W-1:0] column [KERNEL_SIZE];

    assign ls_we = mv1 && (s1_op_reg == c2dzb_pkg::OP_PIXEL);

    // column[k] is the pixel k rows above the current one
    always_comb
    begin
        column[0] = s1_pixel_reg;
        for (int k = 1; k < KERNEL_SIZE; k++)
            column[k] = line_rd_reg[(k-1)*DATA_W +: DATA_W];
        for (int k = 0; k < LS_ROWS; k++)
            ls_wdata[k*DATA_W +: DATA_W] = column[k];
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
            line_mem[s1_col_reg] <= ls_wdata;
    end

    // Read at accept; forward the word written in the same cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (ls_we && (s1_col_reg == in_col_reg))
                line_rd_reg <= ls_wdata;
            else
                line_rd_reg <= line_mem[in_col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Kernel and window: updated as the word leaves stage 1
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] kern_reg [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [DATA_W-1:0] win_reg  [KERNEL_SIZE][KERNEL_SIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KERNEL_SIZE; i++)
                for (int j = 0; j < KERNEL_SIZE; j++)
                begin
                    kern_reg[i][j] <= '0;
                    win_reg[i][j]  <= '0;
                end
        end
        else if (mv1)
        begin
            if (s1_op_reg == c2dzb_pkg::OP_PIXEL)
            begin
                // shift the window left and drop the new column in
                for (int i = 0; i < KERNEL_SIZE; i++)
                begin
                    for (int j = 0; j + 1 < KERNEL_SIZE; j++)
                        win_reg[i][j] <= win_reg[i][j+1];
                    win_reg[i][KERNEL_SIZE-1] <= column[KERNEL_SIZE-1-i];
                end
            end
            else
            begin
                // out-of-range coefficient indexes match no entry
                for (int i = 0; i < KERNEL_SIZE; i++)
                    for (int j = 0; j < KERNEL_SIZE; j++)
                        if (s1_coef_row_reg == c2dzb_pkg::COEF_IDX_W'(i) &&
                            s1_coef_col_reg == c2dzb_pkg::COEF_IDX_W'(j))
                            kern_reg[i][j] <= s1_coef_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: emitting pixels only; window now holds their state
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] s2_row_reg, s3_row_reg, s4_row_reg;
    logic [COL_W-1:0] s2_col_reg, s3_col_reg, s4_col_reg;
    logic             s2_border_reg, s3_border_reg, s4_border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= mv1 && (s1_op_reg == c2dzb_pkg::OP_PIXEL) && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
        begin
            s2_row_reg    <= s1_orow_reg;
            s2_col_reg    <= s1_ocol_reg;
            s2_border_reg <= s1_border_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: one product per window tap
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg [KERNEL_SIZE][KERNEL_SIZE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (rdy3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            for (int i = 0; i < KERNEL_SIZE; i++)
                for (int j = 0; j < KERNEL_SIZE; j++)
                    prod_reg[i][j] <= win_reg[i][j] * kern_reg[i][j];
            s3_row_reg    <= s2_row_reg;
            s3_col_reg    <= s2_col_reg;
            s3_border_reg <= s2_border_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum each kernel row
    // ------------------------------------------------------------------
    logic signed [RSUM_W-1:0] rsum_reg  [KERNEL_SIZE];
    logic signed [RSUM_W-1:0] rsum_next [KERNEL_SIZE];

    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            rsum_next[i] = '0;
            for (int j = 0; j < KERNEL_SIZE; j++)
                rsum_next[i] = rsum_next[i] + RSUM_W'(prod_reg[i][j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (rdy4)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            for (int i = 0; i < KERNEL_SIZE; i++)
                rsum_reg[i] <= rsum_next[i];
            s4_row_reg    <= s3_row_reg;
            s4_col_reg    <= s3_col_reg;
            s4_border_reg <= s3_border_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: total of row sums, zero in the border band
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] total_next;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic signed [SUM_W-1:0] out_value_reg;
    logic                    is_border_reg;

    always_comb
    begin
        total_next = '0;
        if (!s4_border_reg)
        begin
            for (int i = 0; i < KERNEL_SIZE; i++)
                total_next = total_next + SUM_W'(rsum_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rdy_out)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mv4)
        begin
            out_row_reg   <= s4_row_reg;
            out_col_reg   <= s4_col_reg;
            out_value_reg <= total_next;
            is_border_reg <= s4_border_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign is_border = is_border_reg;

endmodule
